/* rtl/pphd_pkg.sv */
// Shared constants, tangent table and pipeline types for the point pair heading block.
`default_nettype none

package pphd_pkg;

	localparam int COORD_BITS  = 16;
	localparam int DIFF_W      = COORD_BITS + 1;          // signed coordinate difference
	localparam int MAG_W       = COORD_BITS;              // |difference| always fits here
	localparam int TAB_W       = 30;                      // tan(k) * 1e9 < 2^30
	localparam int PROD_W      = MAG_W + TAB_W;
	localparam int K_W         = 6;                       // degree index 0..45
	localparam int SRCH_STAGES = K_W;                     // one index bit per stage
	localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int HEAD_W      = 9;
	localparam int OUT_TDATA_W = ((HEAD_W + 7) / 8) * 8;

	localparam logic [TAB_W-1:0]  TAN_SCALE   = 30'd1000000000;
	localparam logic [K_W-1:0]    LIM_SHALLOW = 6'd45;
	localparam logic [K_W-1:0]    LIM_STEEP   = 6'd44;
	localparam logic [HEAD_W-1:0] DEG_89      = 9'd89;
	localparam logic [HEAD_W-1:0] DEG_90      = 9'd90;
	localparam logic [HEAD_W-1:0] DEG_180     = 9'd180;
	localparam logic [HEAD_W-1:0] DEG_360     = 9'd360;

	// octant / quadrant flags that ride alongside the search
	typedef struct packed {
		logic invalid;
		logic dx_neg;
		logic dy_neg;
		logic dy_le0;
		logic steep;    // |dy| > |dx|: search runs on the reciprocal slope
	} pphd_side_t;

	typedef struct packed {
		logic [K_W-1:0]    k;     // best index so far
		logic              eq;    // tan(k) * den == lhs exactly
		logic [PROD_W-1:0] lhs;   // num * 1e9
		logic [MAG_W-1:0]  den;
		pphd_side_t        side;
	} pphd_srch_t;

	// tan(k degrees) * 1e9, rounded
	function automatic logic [TAB_W-1:0] tan_tab(input logic [K_W-1:0] k);
		logic [TAB_W-1:0] v;
		unique case (k)
			6'd0:  v = 30'd0;
			6'd1:  v = 30'd17455065;
			6'd2:  v = 30'd34920769;
			6'd3:  v = 30'd52407779;
			6'd4:  v = 30'd69926812;
			6'd5:  v = 30'd87488664;
			6'd6:  v = 30'd105104235;
			6'd7:  v = 30'd122784561;
			6'd8:  v = 30'd140540835;
			6'd9:  v = 30'd158384440;
			6'd10: v = 30'd176326981;
			6'd11: v = 30'd194380309;
			6'd12: v = 30'd212556562;
			6'd13: v = 30'd230868191;
			6'd14: v = 30'd249328003;
			6'd15: v = 30'd267949192;
			6'd16: v = 30'd286745386;
			6'd17: v = 30'd305730681;
			6'd18: v = 30'd324919696;
			6'd19: v = 30'd344327613;
			6'd20: v = 30'd363970234;
			6'd21: v = 30'd383864035;
			6'd22: v = 30'd404026226;
			6'd23: v = 30'd424474816;
			6'd24: v = 30'd445228685;
			6'd25: v = 30'd466307658;
			6'd26: v = 30'd487732589;
			6'd27: v = 30'd509525449;
			6'd28: v = 30'd531709432;
			6'd29: v = 30'd554309051;
			6'd30: v = 30'd577350269;
			6'd31: v = 30'd600860619;
			6'd32: v = 30'd624869352;
			6'd33: v = 30'd649407593;
			6'd34: v = 30'd674508517;
			6'd35: v = 30'd700207538;
			6'd36: v = 30'd726542528;
			6'd37: v = 30'd753554050;
			6'd38: v = 30'd781285627;
			6'd39: v = 30'd809784033;
			6'd40: v = 30'd839099631;
			6'd41: v = 30'd869286738;
			6'd42: v = 30'd900404044;
			6'd43: v = 30'd932515086;
			6'd44: v = 30'd965688775;
			6'd45: v = 30'd1000000000;
			default: v = '1;   // beyond 45 degrees, never selected
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/pphd_tan_search.sv */
// Pipelined binary search for the largest whole degree whose tangent fits the slope.
`default_nettype none

module pphd_tan_search (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pphd_pkg::pphd_srch_t in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pphd_pkg::pphd_srch_t     out_data
);

	localparam int N = pphd_pkg::SRCH_STAGES;

	logic                 v_q   [N];
	pphd_pkg::pphd_srch_t d_q   [N];
	pphd_pkg::pphd_srch_t src   [N+1];
	logic                 vld   [N+1];
	logic                 rdy   [N+1];

	assign src[0]   = in_data;
	assign vld[0]   = in_valid;
	assign rdy[N]   = out_ready;
	assign in_ready = rdy[0];

	for (genvar j = 0; j < N; j++) begin : g_step
		localparam logic [pphd_pkg::K_W-1:0] STEP_BIT =
			pphd_pkg::K_W'(1) << (pphd_pkg::K_W - 1 - j);

		logic [pphd_pkg::K_W-1:0]    cand;
		logic [pphd_pkg::K_W-1:0]    lim;
		logic [pphd_pkg::PROD_W-1:0] prod;
		logic                        take;
		pphd_pkg::pphd_srch_t        nxt;

		always_comb begin
			cand = src[j].k | STEP_BIT;
			lim  = src[j].side.steep ? pphd_pkg::LIM_STEEP : pphd_pkg::LIM_SHALLOW;
			prod = pphd_pkg::tan_tab(cand) * src[j].den;
			take = (cand <= lim) && (prod <= src[j].lhs);
			nxt  = src[j];
			if (take) begin
				nxt.k  = cand;
				nxt.eq = (prod == src[j].lhs);
			end
		end

		assign rdy[j]   = !v_q[j] || rdy[j+1];
		assign vld[j+1] = v_q[j];
		assign src[j+1] = d_q[j];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (rdy[j]) begin
				v_q[j] <= vld[j];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && vld[j]) begin
				d_q[j] <= nxt;
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign out_data  = d_q[N-1];

endmodule

`default_nettype wire

/* rtl/point_pair_heading_degrees.sv */
// Top level: heading in whole degrees of the vector from a rear point to a front point.
`default_nettype none

// Heading of the vector rear -> front in whole degrees, 0..360 (due east reads 360,
// north 90, west 180, south 270). Off-axis angles are atan(|dy|/|dx|) truncated toward
// zero, then folded into the quadrant; angles that are exact whole degrees come out
// exact because the slope is compared as an integer against tan(k) * 1e9, never rounded.
// Coincident points give heading 0 with the invalid flag (tuser) set.
// Throughput: one transfer per cycle, sustained while m_tready is held high. The stages
// are difference, magnitude/octant, scale, six search steps and quadrant fold. The search
// is a six-step binary search over the 46-entry tangent table, one index bit per stage,
// each stage holding one table lookup and one 30 x 16 multiplier. Every stage has its own
// valid bit and ready, so bubbles are squeezed out and new transfers are taken while a
// result waits at the output.
module point_pair_heading_degrees (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// front_x, front_y, rear_x, rear_y (lowest bits first)
	input  wire logic [pphd_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// heading, zero padded to a byte boundary
	output logic [pphd_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// invalid
	output logic                                     m_tuser
);

	localparam int CB = pphd_pkg::COORD_BITS;

	// input field unpacking
	logic signed [CB-1:0] front_x, front_y, rear_x, rear_y;
	assign front_x = signed'(s_tdata[CB-1:0]);
	assign front_y = signed'(s_tdata[2*CB-1:CB]);
	assign rear_x  = signed'(s_tdata[3*CB-1:2*CB]);
	assign rear_y  = signed'(s_tdata[4*CB-1:3*CB]);

	// per-stage valid and advance
	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3, en_out;
	logic srch_in_ready, srch_valid;
	logic m_tvalid_q;

	assign en_out   = !m_tvalid_q || m_tready;
	assign en_s3    = !v_s3 || srch_in_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// stage 1: signed differences
	logic signed [pphd_pkg::DIFF_W-1:0] dx_c, dy_c, dx_s1, dy_s1;
	assign dx_c = pphd_pkg::DIFF_W'(front_x) - pphd_pkg::DIFF_W'(rear_x);
	assign dy_c = pphd_pkg::DIFF_W'(front_y) - pphd_pkg::DIFF_W'(rear_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
		end
	end

	// stage 2: magnitudes, octant choice, quadrant flags
	logic [pphd_pkg::MAG_W-1:0] adx_c, ady_c;
	logic [pphd_pkg::MAG_W-1:0] num_s2, den_s2;
	pphd_pkg::pphd_side_t       side_c, side_s2;

	always_comb begin
		adx_c          = dx_s1[pphd_pkg::DIFF_W-1] ? pphd_pkg::MAG_W'(-dx_s1)
		                                           : pphd_pkg::MAG_W'(dx_s1);
		ady_c          = dy_s1[pphd_pkg::DIFF_W-1] ? pphd_pkg::MAG_W'(-dy_s1)
		                                           : pphd_pkg::MAG_W'(dy_s1);
		side_c.invalid = (dx_s1 == '0) && (dy_s1 == '0);
		side_c.dx_neg  = dx_s1[pphd_pkg::DIFF_W-1];
		side_c.dy_neg  = dy_s1[pphd_pkg::DIFF_W-1];
		side_c.dy_le0  = dy_s1[pphd_pkg::DIFF_W-1] || (dy_s1 == '0);
		side_c.steep   = ady_c > adx_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			num_s2  <= side_c.steep ? adx_c : ady_c;
			den_s2  <= side_c.steep ? ady_c : adx_c;
			side_s2 <= side_c;
		end
	end

	// stage 3: scale the numerator, seed the search at 0 degrees
	pphd_pkg::pphd_srch_t srch_s3, srch_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			srch_s3.lhs  <= num_s2 * pphd_pkg::TAN_SCALE;
			srch_s3.k    <= '0;
			srch_s3.eq   <= (num_s2 == '0);   // tan 0 = 0 matches only a zero numerator
			srch_s3.den  <= den_s2;
			srch_s3.side <= side_s2;
		end
	end

	// stages 4..9: table search
	pphd_tan_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (srch_in_ready),
		.in_data   (srch_s3),
		.out_valid (srch_valid),
		.out_ready (en_out),
		.out_data  (srch_out)
	);

	// output stage: undo the octant fold and place in the quadrant
	logic [pphd_pkg::HEAD_W-1:0] f_c, t_c, base_c, head_c;
	logic                        neg_c;
	logic [pphd_pkg::HEAD_W-1:0] heading_q;
	logic                        invalid_q;

	always_comb begin
		f_c = pphd_pkg::HEAD_W'(srch_out.k);
		if (srch_out.side.steep) begin
			// steep: tan(90 - t) brackets the reciprocal slope
			t_c = srch_out.eq ? (pphd_pkg::DEG_90 - f_c) : (pphd_pkg::DEG_89 - f_c);
		end else begin
			t_c = f_c;
		end
		neg_c = srch_out.side.dx_neg ^ srch_out.side.dy_neg;
		if (srch_out.side.dx_neg) begin
			base_c = pphd_pkg::DEG_180;
		end else if (srch_out.side.dy_le0) begin
			base_c = pphd_pkg::DEG_360;
		end else begin
			base_c = '0;
		end
		head_c = neg_c ? (base_c - t_c) : (base_c + t_c);
		if (srch_out.side.invalid) begin
			head_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en_out) begin
			m_tvalid_q <= srch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && srch_valid) begin
			heading_q <= head_c;
			invalid_q <= srch_out.side.invalid;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(pphd_pkg::OUT_TDATA_W - pphd_pkg::HEAD_W){1'b0}}, heading_q};
	assign m_tuser  = invalid_q;

	// checks
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (heading_q <= pphd_pkg::DEG_360))
		else $error("heading above 360");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && invalid_q) |-> (heading_q == '0))
		else $error("invalid result carries a nonzero heading");

	a_search_limit: assert property (@(posedge clk) disable iff (!arst_n)
		srch_valid |-> (srch_out.k <= pphd_pkg::LIM_SHALLOW))
		else $error("search index beyond 45 degrees");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> (m_tvalid_q && $stable(heading_q)
		                               && $stable(invalid_q)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

/* sim/tb_point_pair_heading_degrees.sv */
// Self-checking testbench for point_pair_heading_degrees: directed table, random pairs, stalls.
`default_nettype none

module tb_point_pair_heading_degrees;

	localparam int CB             = pphd_pkg::COORD_BITS;
	localparam int HW             = pphd_pkg::HEAD_W;
	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 12;
	localparam int N_RANDOM       = 1150;
	localparam int DRAIN_CYCLES   = 40;      // pipeline is 10 deep
	localparam int TIMEOUT_CYCLES = 600000;
	localparam int HOLD_AFTER     = 250;     // results seen before the long sink stall
	localparam int HOLD_CYCLES    = 150;

	localparam int QUARTER = 90;
	localparam int HALF    = 180;
	localparam int FULL    = 360;
	localparam longint unsigned SLOPE_SCALE = 64'd1000000000;

	typedef logic signed [CB-1:0] coord_t;
	typedef longint unsigned      wide_t;

	typedef struct packed {
		logic [HW-1:0] heading;
		logic          invalid;
	} heading_t;

	typedef struct {
		coord_t   fx, fy, rx, ry;
		bit       typed;    // want is written in the table, not predicted
		heading_t want;
	} pair_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [pphd_pkg::IN_TDATA_W-1:0]     s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [pphd_pkg::OUT_TDATA_W-1:0]    m_tdata;
	logic                                m_tuser;

	heading_t  offered_heading;        // expectation travelling with s_tdata
	heading_t  pending_headings[$];
	pair_row_t directed_rows[$];
	int        fail_count;
	int        results_seen;
	bit        hold_off;
	bit        hold_done;

	point_pair_heading_degrees dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("[FAIL] regression broken");
		$finish;
	end

	// tan(k degrees) scaled by 1e9, rounded to nearest
	function automatic longint unsigned tan_e9(input int k);
		case (k)
			0:  return 64'd0;
			1:  return 64'd17455065;
			2:  return 64'd34920769;
			3:  return 64'd52407779;
			4:  return 64'd69926812;
			5:  return 64'd87488664;
			6:  return 64'd105104235;
			7:  return 64'd122784561;
			8:  return 64'd140540835;
			9:  return 64'd158384440;
			10: return 64'd176326981;
			11: return 64'd194380309;
			12: return 64'd212556562;
			13: return 64'd230868191;
			14: return 64'd249328003;
			15: return 64'd267949192;
			16: return 64'd286745386;
			17: return 64'd305730681;
			18: return 64'd324919696;
			19: return 64'd344327613;
			20: return 64'd363970234;
			21: return 64'd383864035;
			22: return 64'd404026226;
			23: return 64'd424474816;
			24: return 64'd445228685;
			25: return 64'd466307658;
			26: return 64'd487732589;
			27: return 64'd509525449;
			28: return 64'd531709432;
			29: return 64'd554309051;
			30: return 64'd577350269;
			31: return 64'd600860619;
			32: return 64'd624869352;
			33: return 64'd649407593;
			34: return 64'd674508517;
			35: return 64'd700207538;
			36: return 64'd726542528;
			37: return 64'd753554050;
			38: return 64'd781285627;
			39: return 64'd809784033;
			40: return 64'd839099631;
			41: return 64'd869286738;
			42: return 64'd900404044;
			43: return 64'd932515086;
			44: return 64'd965688775;
			default: return 64'd1000000000;
		endcase
	endfunction

	// largest whole degree k <= lim with tan(k) <= num/den; tie reports an exact hit
	function automatic int degree_floor(input longint unsigned num, input longint unsigned den,
	                                    input int lim, output bit exact);
		longint unsigned lhs;
		int k;
		lhs = num * SLOPE_SCALE;
		k = 0;
		for (int i = 1; i <= lim; i++)
			if (tan_e9(i) * den <= lhs)
				k = i;
		exact = (tan_e9(k) * den == lhs);
		return k;
	endfunction

	function automatic heading_t predict_heading(input logic [pphd_pkg::IN_TDATA_W-1:0] d);
		coord_t fx, fy, rx, ry;
		int dx, dy, t, f, dir;
		longint unsigned a, b;
		bit exact;
		heading_t h;
		fx = d[CB-1:0];
		fy = d[2*CB-1:CB];
		rx = d[3*CB-1:2*CB];
		ry = d[4*CB-1:3*CB];
		dx = int'(fx) - int'(rx);
		dy = int'(fy) - int'(ry);
		if (dx == 0 && dy == 0) begin
			h.heading = '0;
			h.invalid = 1'b1;
			return h;
		end
		if (dx == 0) begin
			dir = (dy > 0) ? QUARTER : -QUARTER;
		end else begin
			a = wide_t'(dy < 0 ? -dy : dy);
			b = wide_t'(dx < 0 ? -dx : dx);
			if (a <= b) begin
				t = degree_floor(a, b, 45, exact);
			end else begin
				// steep: search the reciprocal slope, then reflect about 90
				f = degree_floor(b, a, 44, exact);
				t = exact ? QUARTER - f : QUARTER - 1 - f;
			end
			dir = ((dx < 0) != (dy < 0)) ? -t : t;
		end
		if (dx < 0)
			dir += HALF;
		else if (dy <= 0)
			dir += FULL;
		if (dir > FULL)
			dir -= FULL;
		h.heading = dir[HW-1:0];
		h.invalid = 1'b0;
		return h;
	endfunction

	function automatic logic [pphd_pkg::IN_TDATA_W-1:0] pack_pair(input coord_t fx, input coord_t fy,
	                                                             input coord_t rx, input coord_t ry);
		logic [pphd_pkg::IN_TDATA_W-1:0] d;
		d = '0;
		d[4*CB-1:0] = {ry, rx, fy, fx};
		return d;
	endfunction

	function automatic logic [pphd_pkg::IN_TDATA_W-1:0] random_pair();
		coord_t fx, fy, rx, ry;
		int roll, m, k, sa, sb, tmp;
		roll = $urandom_range(0, 99);
		rx = coord_t'($urandom);
		ry = coord_t'($urandom);
		fx = coord_t'($urandom);
		fy = coord_t'($urandom);
		if (roll < 35) begin
			// anything goes, deltas wrap freely
		end else if (roll < 55) begin
			// near neighbours, the odd one coincident
			fx = coord_t'(int'(rx) + int'($urandom_range(0, 80)) - 40);
			fy = coord_t'(int'(ry) + int'($urandom_range(0, 80)) - 40);
		end else if (roll < 65) begin
			if ($urandom_range(0, 1))
				fx = rx;
			else
				fy = ry;
		end else if (roll < 75) begin
			// exact diagonal, kept clear of wrap
			rx = coord_t'(int'($urandom_range(0, 32767)) - 16384);
			ry = coord_t'(int'($urandom_range(0, 32767)) - 16384);
			m  = $urandom_range(1, 16384);
			fx = coord_t'(int'(rx) + ($urandom_range(0, 1) ? m : -m));
			fy = coord_t'(int'(ry) + ($urandom_range(0, 1) ? m : -m));
		end else if (roll < 80) begin
			fx = rx;
			fy = ry;
		end else begin
			// slope within one step of a tangent boundary
			k  = $urandom_range(1, 44);
			sb = $urandom_range(1, 30000);
			sa = int'((tan_e9(k) * wide_t'(sb)) / SLOPE_SCALE)
			     + int'($urandom_range(0, 2)) - 1;
			if (sa < 0)
				sa = 0;
			if ($urandom_range(0, 1)) begin
				tmp = sa;
				sa  = sb;
				sb  = tmp;
			end
			rx = coord_t'(int'($urandom_range(0, 2000)) - 1000);
			ry = coord_t'(int'($urandom_range(0, 2000)) - 1000);
			fx = coord_t'(int'(rx) + ($urandom_range(0, 1) ? sb : -sb));
			fy = coord_t'(int'(ry) + ($urandom_range(0, 1) ? sa : -sa));
		end
		return pack_pair(fx, fy, rx, ry);
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_row(input int fx, input int fy, input int rx, input int ry,
	                       input bit typed, input int heading, input bit invalid);
		pair_row_t r;
		r.fx = coord_t'(fx);
		r.fy = coord_t'(fy);
		r.rx = coord_t'(rx);
		r.ry = coord_t'(ry);
		r.typed = typed;
		r.want.heading = heading[HW-1:0];
		r.want.invalid = invalid;
		directed_rows.push_back(r);
	endtask

	// present one pair and hold it until the transfer
	task automatic offer_pair(input logic [pphd_pkg::IN_TDATA_W-1:0] d, input heading_t want);
		int gap;
		gap = hold_off ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid        <= 1'b1;
		s_tdata         <= d;
		offered_heading <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	// scoreboard: values seen here are those before the edge
	always @(posedge clk) begin
		heading_t got, want;
		if (s_tvalid && s_tready)
			pending_headings.push_back(offered_heading);
		if (m_tvalid && m_tready) begin
			got.heading = m_tdata[HW-1:0];
			got.invalid = m_tuser;
			results_seen++;
			if (pending_headings.size() == 0) begin
				$display("%0t unexpected result: expected none, got heading %0d invalid %0b",
				         $time, got.heading, got.invalid);
				fail_count++;
			end else begin
				want = pending_headings.pop_front();
				if (got.heading !== want.heading) begin
					$display("%0t heading mismatch: expected %0d, got %0d",
					         $time, want.heading, got.heading);
					fail_count++;
				end
				if (got.invalid !== want.invalid) begin
					$display("%0t invalid mismatch: expected %0b, got %0b",
					         $time, want.invalid, got.invalid);
					fail_count++;
				end
			end
		end
	end

	// sink: random ready pattern, one long hold-off to back the pipeline up
	initial begin
		int run, gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_off  = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off  = 1'b0;
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		pair_row_t r;
		heading_t w;
		logic [pphd_pkg::IN_TDATA_W-1:0] d;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		offered_heading = '0;
		fail_count      = 0;
		results_seen    = 0;
		hold_off        = 1'b0;
		hold_done       = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coincident points, at zero and at both corners
		add_row(0, 0, 0, 0, 1, 0, 1);
		add_row(-32768, -32768, -32768, -32768, 1, 0, 1);
		add_row(32767, 32767, 32767, 32767, 1, 0, 1);
		// compass points and diagonals, unit length
		add_row(1, 0, 0, 0, 1, 360, 0);
		add_row(0, 1, 0, 0, 1, 90, 0);
		add_row(-1, 0, 0, 0, 1, 180, 0);
		add_row(0, -1, 0, 0, 1, 270, 0);
		add_row(1, 1, 0, 0, 1, 45, 0);
		add_row(-1, 1, 0, 0, 1, 135, 0);
		add_row(-1, -1, 0, 0, 1, 225, 0);
		add_row(1, -1, 0, 0, 1, 315, 0);
		// full-span deltas
		add_row(32767, 0, -32768, 0, 1, 360, 0);
		add_row(-32768, 0, 32767, 0, 1, 180, 0);
		add_row(0, 32767, 0, -32768, 1, 90, 0);
		add_row(0, -32768, 0, 32767, 1, 270, 0);
		add_row(32767, 32767, -32768, -32768, 1, 45, 0);
		add_row(-32768, 32767, 32767, -32768, 1, 135, 0);
		// steepest and shallowest slopes, bit patterns, near a tangent edge
		add_row(1, 32767, 0, -32768, 0, 0, 0);
		add_row(32767, -32768, -32768, -32767, 0, 0, 0);
		add_row(-1, -32768, 0, 32767, 0, 0, 0);
		add_row(4, 3, 0, 0, 0, 0, 0);
		add_row(-3, -4, 0, 0, 0, 0, 0);
		add_row(21845, -21846, -21846, 21845, 0, 0, 0);
		add_row(-21846, 21845, 21845, -21846, 0, 0, 0);
		add_row(1000, 577, 0, 0, 0, 0, 0);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			d = pack_pair(r.fx, r.fy, r.rx, r.ry);
			w = r.typed ? r.want : predict_heading(d);
			offer_pair(d, w);
		end

		repeat (N_RANDOM) begin
			d = random_pair();
			offer_pair(d, predict_heading(d));
		end
		s_tvalid <= 1'b0;

		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
